// ----- sv/assert_macros.svh -----
// Assertion macros shared by the list engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- sv/slec_pkg.sv -----
// Codes and cell control types for the list engine
package slec_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_POS = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam logic [1:0] RULE_EQ = 2'd0;
  localparam logic [1:0] RULE_GE = 2'd1;
  localparam logic [1:0] RULE_LE = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_COMPARE,
    CELL_SCAN
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [7:0]         pos;
    logic [1:0]         rule;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// ----- sv/slec_cell.sv -----
// One list cell: holds an entry, shifts with its neighbours, compares and passes hit flags
module slec_cell #(
  parameter int unsigned K     = 0,
  parameter int unsigned LEN_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slec_pkg::cell_ctl_t ctl_i,
  input  logic [LEN_W-1:0]    len_i,
  input  logic signed [31:0]  left_i,
  input  logic signed [31:0]  right_i,
  input  logic                hit_right_i,
  output logic signed [31:0]  data_o,
  output logic                hit_o,
  output logic signed [31:0]  tap_o
);

  logic signed [31:0] data_q;
  logic               hit_q;
  logic               at_pos;
  logic               past_pos;
  logic               in_list;
  logic               match;

  assign at_pos   = (32'(ctl_i.pos) == 32'(K + 1));
  assign past_pos = (32'(ctl_i.pos) <= 32'(K));
  assign in_list  = (32'(len_i) > 32'(K));

  always_comb begin
    case (ctl_i.rule)
      slec_pkg::RULE_EQ: match = (data_q == ctl_i.value);
      slec_pkg::RULE_GE: match = (data_q >= ctl_i.value);
      slec_pkg::RULE_LE: match = (data_q <= ctl_i.value);
      default:           match = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      slec_pkg::CELL_INSERT: begin
        if (at_pos) begin
          data_q <= ctl_i.value;
        end else if (past_pos) begin
          data_q <= left_i;
        end
      end
      slec_pkg::CELL_DELETE: begin
        if (at_pos || past_pos) begin
          data_q <= right_i;
        end
      end
      default: begin
        data_q <= data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      case (ctl_i.op)
        slec_pkg::CELL_COMPARE: hit_q <= in_list && match;
        slec_pkg::CELL_SCAN:    hit_q <= hit_right_i;
        default:                hit_q <= hit_q;
      endcase
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;
  assign tap_o  = at_pos ? data_q : 32'sd0;

endmodule

// ----- sv/sequential_list_engine_core.sv -----
// Top level of the list engine: request sequencer driving a chain of entry cells
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------------
//  request   | start_i / busy_o     | op_i, position_i, value_i
//  result    | done_o (one cycle)   | status_o, found_position_o, removed_value_o,
//            |                      | list_count_o
//  config    | cfg_we_i             | cfg_wdata_i (match rule)
//
// Insert, delete and unused ops go from accept in idle to an execute state in which the cells
// at and past the position shift at once; a bad or unused op leaves them as they are. Locate
// compares in all cells in parallel in the execute state, then in the scan state the hit flags
// move down the chain 16 places a cycle (CAPACITY if smaller) past a priority picker.
// Reset empties the list and sets the match rule to equal; entries need no clearing.
// The result strobe cannot be stalled; a new request may start in the cycle it shows.
`include "assert_macros.svh"
module sequential_list_engine_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [7:0]         found_position_o,
  output logic signed [31:0] removed_value_o,
  output logic [7:0]         list_count_o
);

  localparam int unsigned LEN_W  = $clog2(CAPACITY + 1);
  localparam int unsigned BASE_W = LEN_W + 1;
  localparam int unsigned GROUP  = (CAPACITY < 16) ? CAPACITY : 16;
  localparam int unsigned GRP_W  = $clog2(GROUP);
  localparam int unsigned CW     = ((LEN_W > 8) ? LEN_W : 8) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  state_e             state_q;
  logic [1:0]         op_q;
  logic [7:0]         pos_q;
  logic signed [31:0] val_q;
  logic [1:0]         rule_q;
  logic [LEN_W-1:0]   len_q;
  logic [BASE_W-1:0]  base_q;
  logic               done_q;
  logic [1:0]         status_q;
  logic [7:0]         found_q;
  logic signed [31:0] removed_q;
  logic [7:0]         count_q;

  slec_pkg::cell_ctl_t ctl;
  logic signed [31:0] data   [CAPACITY];
  logic signed [31:0] tap    [CAPACITY];
  logic [CAPACITY-1:0] hit;

  logic               ins_bad;
  logic               full;
  logic               del_bad;
  logic signed [31:0] removed;
  logic               grp_any;
  logic [GRP_W-1:0]   grp_idx;
  logic [BASE_W-1:0]  found_pos;
  logic               scan_end;

  assign ins_bad = (pos_q == 8'd0) || (CW'(pos_q) > (CW'(len_q) + CW'(1)));
  assign full    = (len_q == LEN_W'(CAPACITY));
  assign del_bad = (pos_q == 8'd0) || (CW'(pos_q) > CW'(len_q));

  always_comb begin
    ctl.op    = slec_pkg::CELL_HOLD;
    ctl.pos   = pos_q;
    ctl.rule  = rule_q;
    ctl.value = val_q;
    if (state_q == ST_EXEC) begin
      case (op_q)
        slec_pkg::OP_INSERT: begin
          if (!ins_bad && !full) begin
            ctl.op = slec_pkg::CELL_INSERT;
          end
        end
        slec_pkg::OP_DELETE: begin
          if (!del_bad) begin
            ctl.op = slec_pkg::CELL_DELETE;
          end
        end
        slec_pkg::OP_LOCATE: ctl.op = slec_pkg::CELL_COMPARE;
        default:             ctl.op = slec_pkg::CELL_HOLD;
      endcase
    end else if (state_q == ST_SCAN) begin
      ctl.op = slec_pkg::CELL_SCAN;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic               hit_right;

    if (k == 0) begin : g_first
      assign left = 32'sd0;
    end else begin : g_mid_l
      assign left = data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right = 32'sd0;
    end else begin : g_mid_r
      assign right = data[k+1];
    end

    if (k + GROUP < CAPACITY) begin : g_hit_in
      assign hit_right = hit[k+GROUP];
    end else begin : g_hit_end
      assign hit_right = 1'b0;
    end

    slec_cell #(
      .K     (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .len_i       (len_q),
      .left_i      (left),
      .right_i     (right),
      .hit_right_i (hit_right),
      .data_o      (data[k]),
      .hit_o       (hit[k]),
      .tap_o       (tap[k])
    );
  end

  always_comb begin
    removed = 32'sd0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | tap[i];
    end
  end

  always_comb begin
    grp_any = 1'b0;
    grp_idx = '0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (hit[i]) begin
        grp_any = 1'b1;
        grp_idx = GRP_W'(i);
      end
    end
  end

  assign found_pos = base_q + BASE_W'(grp_idx) + BASE_W'(1);
  assign scan_end  = ((base_q + BASE_W'(GROUP)) >= BASE_W'(len_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= '0;
      pos_q     <= '0;
      val_q     <= '0;
      rule_q    <= slec_pkg::RULE_EQ;
      len_q     <= '0;
      base_q    <= '0;
      done_q    <= 1'b0;
      status_q  <= slec_pkg::STATUS_OK;
      found_q   <= '0;
      removed_q <= '0;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        rule_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            op_q    <= op_i;
            pos_q   <= position_i;
            val_q   <= value_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          found_q <= '0;
          unique case (op_q)
            slec_pkg::OP_INSERT: begin
              removed_q <= '0;
              if (ins_bad) begin
                status_q <= slec_pkg::STATUS_BAD_POS;
                count_q  <= 8'(len_q);
              end else if (full) begin
                status_q <= slec_pkg::STATUS_FULL;
                count_q  <= 8'(len_q);
              end else begin
                status_q <= slec_pkg::STATUS_OK;
                len_q    <= len_q + LEN_W'(1);
                count_q  <= 8'(len_q + LEN_W'(1));
              end
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            slec_pkg::OP_DELETE: begin
              if (del_bad) begin
                status_q  <= slec_pkg::STATUS_BAD_POS;
                removed_q <= '0;
                count_q   <= 8'(len_q);
              end else begin
                status_q  <= slec_pkg::STATUS_OK;
                removed_q <= removed;
                len_q     <= len_q - LEN_W'(1);
                count_q   <= 8'(len_q - LEN_W'(1));
              end
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            slec_pkg::OP_LOCATE: begin
              status_q  <= slec_pkg::STATUS_OK;
              removed_q <= '0;
              count_q   <= 8'(len_q);
              base_q    <= '0;
              done_q    <= 1'b0;
              state_q   <= ST_SCAN;
            end
            default: begin
              status_q  <= slec_pkg::STATUS_OK;
              removed_q <= '0;
              count_q   <= 8'(len_q);
              done_q    <= 1'b1;
              state_q   <= ST_IDLE;
            end
          endcase
        end
        ST_SCAN: begin
          if (grp_any) begin
            found_q <= 8'(found_pos);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (scan_end) begin
            found_q <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            base_q <= base_q + BASE_W'(GROUP);
            done_q <= 1'b0;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign removed_value_o  = removed_q;
  assign list_count_o     = count_q;

  `ASSERT_NEVER(a_len_bound, CW'(len_q) > CW'(CAPACITY), "list length beyond capacity")
  `ASSERT_PROP(a_start_busy, start_i && !busy_o |=> busy_o, "accepted transaction not started")
  `ASSERT_PROP(a_done_idle, done_o |-> !busy_o, "result shown while still busy")
  `ASSERT_PROP(a_full_len, done_o && status_o == slec_pkg::STATUS_FULL |-> full,
               "full status with room left")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the list engine: directed table, then mixed random traffic
`timescale 1ns / 1ps
module tb;
  import slec_pkg::*;

  localparam int unsigned CAPACITY = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] RULE_NONE = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int SEGMENTS = 10;
  localparam int SEG_ITEMS = 115;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found;
    logic signed [31:0] removed;
    logic [7:0]         count;
  } list_result_t;

  typedef struct packed {
    logic               cfg_wr;
    logic [1:0]         rule;
    logic [1:0]         op;
    logic [7:0]         pos;
    logic signed [31:0] val;
    logic               typed;
    list_result_t       exp;
  } stim_row_t;

  typedef enum logic [1:0] {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_e;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         op_i;
  logic [7:0]         position_i;
  logic signed [31:0] value_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_wdata_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [7:0]         found_position_o;
  logic signed [31:0] removed_value_o;
  logic [7:0]         list_count_o;

  logic signed [31:0] list_entries [CAPACITY];
  int unsigned        list_fill;
  logic [1:0]         match_rule;

  list_result_t       awaited_results [$];
  list_result_t       oldest;
  int unsigned        mismatch_count;

  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{1'b0, RULE_EQ,   OP_DELETE, 8'd1,   32'sd0,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd0}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd0,   32'sd7,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd0}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd2,   32'sd7,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd0}},
    '{1'b0, RULE_EQ,   OP_LOCATE, 8'd0,   32'sd5,     1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd0}},
    '{1'b0, RULE_EQ,   OP_UNUSED, 8'hFF,  -32'sd1,    1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd0}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd1,   VAL_MAX,    1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd1}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd1,   VAL_MIN,    1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd2}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd3,   -32'sd1,    1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd255, 32'sd0,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_INSERT, 8'd5,   32'sd0,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_LOCATE, 8'd0,   VAL_MAX,    1'b1, '{STATUS_OK,      8'd2, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_LOCATE, 8'd0,   -32'sd1,    1'b1, '{STATUS_OK,      8'd3, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_LOCATE, 8'd0,   32'sd12345, 1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_DELETE, 8'd0,   32'sd0,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_DELETE, 8'd4,   32'sd0,     1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_DELETE, 8'd255, VAL_MIN,    1'b1, '{STATUS_BAD_POS, 8'd0, 32'sd0, 8'd3}},
    '{1'b0, RULE_EQ,   OP_DELETE, 8'd2,   32'sd0,     1'b1, '{STATUS_OK,      8'd0, VAL_MAX, 8'd2}},
    '{1'b0, RULE_EQ,   OP_LOCATE, 8'd255, VAL_MIN,    1'b1, '{STATUS_OK,      8'd1, 32'sd0, 8'd2}},
    '{1'b1, RULE_GE,   OP_LOCATE, 8'd0,   32'sd0,     1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd2}},
    '{1'b0, RULE_GE,   OP_LOCATE, 8'd0,   -32'sd1,    1'b1, '{STATUS_OK,      8'd2, 32'sd0, 8'd2}},
    '{1'b1, RULE_LE,   OP_LOCATE, 8'd0,   VAL_MIN,    1'b1, '{STATUS_OK,      8'd1, 32'sd0, 8'd2}},
    '{1'b0, RULE_LE,   OP_LOCATE, 8'd0,   -32'sd2,    1'b1, '{STATUS_OK,      8'd1, 32'sd0, 8'd2}},
    '{1'b1, RULE_NONE, OP_LOCATE, 8'd0,   -32'sd1,    1'b1, '{STATUS_OK,      8'd0, 32'sd0, 8'd2}},
    '{1'b1, RULE_EQ,   OP_INSERT, 8'd2,   32'sd0,     1'b0, '0},
    '{1'b0, RULE_EQ,   OP_DELETE, 8'd3,   32'sd0,     1'b0, '0}
  };

  mix_e segment_mix [SEGMENTS] = '{
    MIX_GROW, MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_SHRINK,
    MIX_BALANCED, MIX_GROW, MIX_GROW, MIX_SHRINK, MIX_BALANCED
  };

  sequential_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .removed_value_o  (removed_value_o),
    .list_count_o     (list_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic rule_hit(input logic signed [31:0] entry,
                                    input logic signed [31:0] key);
    case (match_rule)
      RULE_EQ: return entry == key;
      RULE_GE: return entry >= key;
      RULE_LE: return entry <= key;
      default: return 1'b0;
    endcase
  endfunction

  function automatic list_result_t apply_to_list(input logic [1:0] op, input logic [7:0] pos,
                                                 input logic signed [31:0] val);
    list_result_t r;
    int k;
    int p;
    logic hit;
    r = '0;
    p = int'(pos);
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > int'(list_fill) + 1) begin
          r.status = STATUS_BAD_POS;
        end else if (list_fill >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          for (k = int'(list_fill); k >= p; k--) list_entries[k] = list_entries[k - 1];
          list_entries[p - 1] = val;
          list_fill++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > int'(list_fill)) begin
          r.status = STATUS_BAD_POS;
        end else begin
          r.removed = list_entries[p - 1];
          for (k = p; k < int'(list_fill); k++) list_entries[k - 1] = list_entries[k];
          list_fill--;
        end
      end
      OP_LOCATE: begin
        for (k = 0; k < int'(list_fill) && !hit; k++) begin
          if (rule_hit(list_entries[k], val)) begin
            hit = 1'b1;
            r.found = 8'(k + 1);
          end
        end
      end
      default: ;
    endcase
    r.count = 8'(list_fill);
    return r;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [7:0] pos,
                              input logic signed [31:0] val, input logic typed,
                              input list_result_t typed_exp);
    int gap;
    list_result_t predicted;
    @(negedge clk_i);
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i       = op;
    position_i = pos;
    value_i    = val;
    start_i    = 1'b1;
    do @(posedge clk_i); while (busy_o);
    predicted = apply_to_list(op, pos, val);
    awaited_results.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic write_rule(input logic [1:0] rule);
    @(negedge clk_i);
    start_i = 1'b0;
    wait (awaited_results.size() == 0);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = rule;
    match_rule  = rule;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatch_count++;
      end else begin
        oldest = awaited_results.pop_front();
        if (status_o !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status_o);
          mismatch_count++;
        end
        if (found_position_o !== oldest.found) begin
          $error("found_position: expected %0d, got %0d", oldest.found, found_position_o);
          mismatch_count++;
        end
        if (removed_value_o !== oldest.removed) begin
          $error("removed_value: expected %0d, got %0d", oldest.removed, removed_value_o);
          mismatch_count++;
        end
        if (list_count_o !== oldest.count) begin
          $error("list_count: expected %0d, got %0d", oldest.count, list_count_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int row;
    int seg;
    int n;
    int roll;
    int w_ins;
    int w_del;
    int w_loc;
    logic [1:0] op;
    logic [7:0] pos;
    logic signed [31:0] val;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    op_i           = OP_INSERT;
    position_i     = '0;
    value_i        = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = RULE_EQ;
    list_fill      = 0;
    match_rule     = RULE_EQ;
    mismatch_count = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (directed_table[row].cfg_wr) write_rule(directed_table[row].rule);
      send_request(directed_table[row].op, directed_table[row].pos, directed_table[row].val,
                   directed_table[row].typed, directed_table[row].exp);
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_rule(2'(seg % 4));
      case (segment_mix[seg])
        MIX_GROW:     begin w_ins = 85; w_del = 3;  w_loc = 9;  end
        MIX_SHRINK:   begin w_ins = 5;  w_del = 80; w_loc = 12; end
        default:      begin w_ins = 40; w_del = 35; w_loc = 22; end
      endcase
      for (n = 0; n < SEG_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < w_ins) op = OP_INSERT;
        else if (roll < w_ins + w_del) op = OP_DELETE;
        else if (roll < w_ins + w_del + w_loc) op = OP_LOCATE;
        else op = OP_UNUSED;

        if ($urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, 255));
        else if (op == OP_INSERT) pos = 8'($urandom_range(1, list_fill + 1));
        else if (list_fill > 0) pos = 8'($urandom_range(1, list_fill));
        else pos = 8'($urandom_range(0, 255));

        roll = $urandom_range(0, 99);
        if (op == OP_LOCATE && list_fill > 0 && roll < 40) begin
          val = list_entries[$urandom_range(0, list_fill - 1)];
        end else if (roll < 65) begin
          val = $signed(32'($urandom_range(0, 16))) - 32'sd8;
        end else if (roll < 80) begin
          case ($urandom_range(0, 3))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2:       val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end else begin
          val = $signed($urandom);
        end
        send_request(op, pos, val, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    start_i = 1'b0;
    wait (awaited_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
